@@ design/strict_base64url_decoder_unit_assert.svh @@
// Assertion macros shared by the decoder's modules.
`ifndef STRICT_BASE64URL_DECODER_UNIT_ASSERT_SVH
`define STRICT_BASE64URL_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SBU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SBU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/sbu_pkg.sv @@
// Types, status codes and character classifier for the base64url decoder.
package sbu_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADCHAR  = 3'd1,
		ST_PADPOS   = 3'd2,
		ST_PADLONG  = 3'd3,
		ST_LONE     = 3'd4,
		ST_LEFTOVER = 3'd5
	} status_t;

	typedef struct packed {
		logic       pad;
		logic       bad;
		logic [5:0] sym;
	} cls_t;

	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic       done;
		status_t    status;
	} res_t;

	localparam int unsigned QDEPTH = 2;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r.pad = 1'b0;
		r.bad = 1'b0;
		r.sym = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.sym = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.sym = 6'(c - 8'h47);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.sym = 6'(c + 8'h04);
		end else if (c == 8'h2D) begin
			r.sym = 6'd62;
		end else if (c == 8'h5F) begin
			r.sym = 6'd63;
		end else if (c == 8'h3D) begin
			r.pad = 1'b1;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ design/sbu_front.sv @@
// Front end: accept characters, classify, track quartet state, form results.
module sbu_front import sbu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	input  logic       q_full,
	output logic       push,
	output res_t       push_res
);

	logic [5:0] hold_q;
	logic [1:0] phase_q;
	logic [1:0] pad_q;
	logic       seen_q;
	status_t    err_q;

	cls_t       cls;
	logic [5:0] hold_d;
	logic [1:0] phase_d;
	logic [1:0] pad_d;
	logic       seen_d;
	status_t    err_d;
	logic       have;
	logic [7:0] data;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cls     = classify(in_char);
		hold_d  = hold_q;
		phase_d = phase_q;
		pad_d   = pad_q;
		seen_d  = seen_q;
		err_d   = err_q;
		have    = 1'b0;
		data    = '0;
		if (err_q == ST_OK) begin
			if (cls.bad) begin
				err_d = ST_BADCHAR;
			end else if (cls.pad) begin
				if (!seen_q) begin
					err_d = ST_PADPOS;
				end else if (pad_q >= 2'd2) begin
					err_d = ST_PADLONG;
				end else begin
					pad_d = pad_q + 2'd1;
				end
			end else if (pad_q != 2'd0) begin
				err_d = ST_PADPOS;
			end else begin
				case (phase_q)
					2'd0: begin
						hold_d = cls.sym;
					end
					2'd1: begin
						data   = {hold_q, cls.sym[5:4]};
						hold_d = {2'b00, cls.sym[3:0]};
						have   = 1'b1;
					end
					2'd2: begin
						data   = {hold_q[3:0], cls.sym[5:2]};
						hold_d = {4'b0000, cls.sym[1:0]};
						have   = 1'b1;
					end
					default: begin
						data   = {hold_q[1:0], cls.sym};
						hold_d = '0;
						have   = 1'b1;
					end
				endcase
				phase_d = phase_q + 2'd1;
			end
			seen_d = 1'b1;
		end
		if (in_last && err_d == ST_OK) begin
			if (phase_d == 2'd1) begin
				err_d = ST_LONE;
			end else if (phase_d == 2'd2 && hold_d[3:0] != 4'd0) begin
				err_d = ST_LEFTOVER;
			end else if (phase_d == 2'd3 && hold_d[1:0] != 2'd0) begin
				err_d = ST_LEFTOVER;
			end
		end
		if (err_d != ST_OK) begin
			have = 1'b0;
			data = '0;
		end
	end

	assign push                = accept && (have || in_last);
	assign push_res.data       = data;
	assign push_res.data_valid = have;
	assign push_res.done       = in_last;
	assign push_res.status     = err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= '0;
			phase_q <= '0;
			pad_q   <= '0;
			seen_q  <= 1'b0;
			err_q   <= ST_OK;
		end else if (accept) begin
			if (in_last) begin
				hold_q  <= '0;
				phase_q <= '0;
				pad_q   <= '0;
				seen_q  <= 1'b0;
				err_q   <= ST_OK;
			end else begin
				hold_q  <= hold_d;
				phase_q <= phase_d;
				pad_q   <= pad_d;
				seen_q  <= seen_d;
				err_q   <= err_d;
			end
		end
	end

`include "strict_base64url_decoder_unit_assert.svh"
	`SBU_ASSERT_NEXT(a_last_clears, clk, arst_n, accept && in_last, phase_q == 2'd0 && pad_q == 2'd0 && err_q == ST_OK && !seen_q)
	`SBU_ASSERT_IMPLY(a_pad_excl, clk, arst_n, pad_q != 2'd0, seen_q)

endmodule

@@ design/sbu_fifo.sv @@
// Short result queue between the front end and the output stage.
module sbu_fifo import sbu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic full,
	output logic q_valid,
	input  logic pop,
	output res_t pop_res
);

	localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	res_t          mem [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full    = cnt_q == CW'(QDEPTH);
	assign q_valid = cnt_q != '0;
	assign do_pop  = pop && q_valid;
	assign pop_res = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push && !full, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`include "strict_base64url_decoder_unit_assert.svh"
	`SBU_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, !full)

endmodule

@@ design/sbu_back.sv @@
// Output stage: hold one request for the consumer while the queue refills.
module sbu_back import sbu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  res_t       pop_res,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       done_res,
	output logic [2:0] status
);

	logic out_valid_q;
	res_t res_q;

	assign pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= pop_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = res_q.data_valid ? res_q.data : 8'd0;
	assign byte_valid = res_q.data_valid;
	assign done_res   = res_q.done;
	assign status     = res_q.status;

`include "strict_base64url_decoder_unit_assert.svh"
	`SBU_ASSERT_IMPLY(a_byte_ok, clk, arst_n, out_valid_q && res_q.data_valid, res_q.status == ST_OK)

endmodule

@@ design/strict_base64url_decoder_unit.sv @@
// Top level of the strict base64url decoder: front end, result queue, output stage.
// Throughput: one character per cycle while the queue is not full; the front end decodes each in its accept cycle.
// A result enters the queue when its character is accepted and is offered from the output register once popped.
// A two-entry queue and the output register let input and output stall independently.
// Reset (arst_n low) clears decode state, error, queue and output valid at once.
module strict_base64url_decoder_unit import sbu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       done_res,
	output logic [2:0] status
);

	logic q_full;
	logic push;
	res_t push_res;
	logic q_valid;
	logic pop;
	res_t pop_res;

	sbu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_char  (in_char),
		.in_last  (in_last),
		.q_full   (q_full),
		.push     (push),
		.push_res (push_res)
	);

	sbu_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.full     (q_full),
		.q_valid  (q_valid),
		.pop      (pop),
		.pop_res  (pop_res)
	);

	sbu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.pop_res    (pop_res),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.done_res   (done_res),
		.status     (status)
	);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the strict base64url decoder: directed texts, random texts, checks.
`timescale 1ns / 1ps

module tb_top import sbu_pkg::*; ();

	typedef logic [7:0] char_q[$];

	class b64url_decode_board;
		res_t       pending_decodes[$];
		logic [5:0] bit_hold;
		logic [1:0] quartet_phase;
		logic [1:0] pad_count;
		logic       any_seen;
		status_t    first_err;
		int         n_fail;

		function new();
			clear_text();
			n_fail = 0;
		endfunction

		function void clear_text();
			bit_hold = '0;
			quartet_phase = '0;
			pad_count = '0;
			any_seen = 1'b0;
			first_err = ST_OK;
		endfunction

		function void decode_char(logic [7:0] c, logic last);
			logic [5:0] v;
			logic       is_pad;
			logic       is_bad;
			logic       have;
			logic [7:0] b;
			res_t       r;
			v = '0;
			is_pad = 1'b0;
			is_bad = 1'b0;
			have = 1'b0;
			b = '0;
			if (first_err == ST_OK) begin
				if (c inside {["A":"Z"]}) begin
					v = 6'(c - "A");
				end else if (c inside {["a":"z"]}) begin
					v = 6'(c - "a" + 8'd26);
				end else if (c inside {["0":"9"]}) begin
					v = 6'(c - "0" + 8'd52);
				end else if (c == "-") begin
					v = 6'd62;
				end else if (c == "_") begin
					v = 6'd63;
				end else if (c == "=") begin
					is_pad = 1'b1;
				end else begin
					is_bad = 1'b1;
				end
				if (is_bad) begin
					first_err = ST_BADCHAR;
				end else if (is_pad) begin
					if (!any_seen)
						first_err = ST_PADPOS;
					else if (pad_count == 2'd2)
						first_err = ST_PADLONG;
					else
						pad_count++;
				end else if (pad_count != 2'd0) begin
					first_err = ST_PADPOS;
				end else begin
					case (quartet_phase)
						2'd0: begin
							bit_hold = v;
						end
						2'd1: begin
							b = {bit_hold, v[5:4]};
							bit_hold = {2'b00, v[3:0]};
							have = 1'b1;
						end
						2'd2: begin
							b = {bit_hold[3:0], v[5:2]};
							bit_hold = {4'b0000, v[1:0]};
							have = 1'b1;
						end
						default: begin
							b = {bit_hold[1:0], v};
							bit_hold = '0;
							have = 1'b1;
						end
					endcase
					quartet_phase++;
				end
				any_seen = 1'b1;
			end
			if (last && first_err == ST_OK) begin
				if (quartet_phase == 2'd1)
					first_err = ST_LONE;
				else if (quartet_phase == 2'd2 && bit_hold[3:0] != 4'd0)
					first_err = ST_LEFTOVER;
				else if (quartet_phase == 2'd3 && bit_hold[1:0] != 2'd0)
					first_err = ST_LEFTOVER;
			end
			if (first_err != ST_OK)
				have = 1'b0;
			if (have || last) begin
				r.data = have ? b : 8'h00;
				r.data_valid = have;
				r.done = last;
				r.status = first_err;
				pending_decodes.push_back(r);
			end
			if (last)
				clear_text();
		endfunction

		function void check_result(logic [7:0] ob, logic bv, logic dn, logic [2:0] st);
			res_t e;
			if (pending_decodes.size() == 0) begin
				$error("unexpected result: out_byte %0h byte_valid %0b done_res %0b status %0d",
					ob, bv, dn, st);
				n_fail++;
				return;
			end
			e = pending_decodes.pop_front();
			if (ob !== e.data) begin
				$error("out_byte: expected %0h, actual %0h", e.data, ob);
				n_fail++;
			end
			if (bv !== e.data_valid) begin
				$error("byte_valid: expected %0b, actual %0b", e.data_valid, bv);
				n_fail++;
			end
			if (dn !== e.done) begin
				$error("done_res: expected %0b, actual %0b", e.done, dn);
				n_fail++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				n_fail++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 400000;
	localparam int CHARS_PER_PHASE = 633;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_char = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       done_res;
	logic [2:0] status;

	int send_idle_pct = 6;
	int recv_idle_pct = 69;
	int cycle_count = 0;

	b64url_decode_board board;

	strict_base64url_decoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.done_res   (done_res),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_byte, byte_valid, done_res, status);
	end

	function automatic logic [7:0] sym_char(logic [5:0] v);
		if (v < 6'd26)
			return 8'("A") + 8'(v);
		else if (v < 6'd52)
			return 8'("a") + 8'(v - 6'd26);
		else if (v < 6'd62)
			return 8'("0") + 8'(v - 6'd52);
		else if (v == 6'd62)
			return 8'("-");
		else
			return 8'("_");
	endfunction

	function automatic char_q to_chars(string s);
		char_q q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	task automatic send_char(logic [7:0] c, logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		in_last <= last;
		do
			@(posedge clk);
		while (!in_ready);
		board.decode_char(c, last);
	endtask

	task automatic send_text(char_q t);
		for (int i = 0; i < t.size(); i++)
			send_char(t[i], i == t.size() - 1);
	endtask

	task automatic make_text(output char_q t);
		int         nbytes;
		int         n;
		int         npad;
		int         pos;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		t = {};
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				t.push_back(8'($urandom_range(0, 255)));
			return;
		end
		nbytes = $urandom_range(1, 9);
		while (nbytes > 0) begin
			n = (nbytes > 3) ? 3 : nbytes;
			b0 = 8'($urandom);
			b1 = (n > 1) ? 8'($urandom) : 8'h00;
			b2 = (n > 2) ? 8'($urandom) : 8'h00;
			t.push_back(sym_char(b0[7:2]));
			t.push_back(sym_char({b0[1:0], b1[7:4]}));
			if (n > 1)
				t.push_back(sym_char({b1[3:0], b2[7:6]}));
			if (n > 2)
				t.push_back(sym_char(b2[5:0]));
			nbytes -= n;
		end
		if (t.size() % 4 != 0)
			npad = $urandom_range(0, 2);
		else
			npad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
		repeat (npad)
			t.push_back("=");
		if ($urandom_range(0, 99) < 30) begin
			pos = $urandom_range(0, t.size() - 1);
			case ($urandom_range(0, 5))
				0: t[pos] = 8'($urandom_range(0, 255));
				1: t.insert(pos, "=");
				2: begin
					repeat (3)
						t.push_back("=");
				end
				3: t.push_front("=");
				4: begin
					if (t.size() > 1)
						t.delete(pos);
				end
				default: begin
					pos = t.size() - 1;
					while (pos > 0 && t[pos] == "=")
						pos--;
					t[pos] = sym_char(6'($urandom));
				end
			endcase
		end
	endtask

	initial begin
		char_q t;
		int    n_sent;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		t = {8'h00};
		send_text(t);
		t = {8'h51, 8'hFF, 8'h41};
		send_text(t);
		send_text(to_chars("="));
		send_text(to_chars("AQ=="));
		send_text(to_chars("AQ=A"));
		send_text(to_chars("AQ==="));
		send_text(to_chars("-"));
		send_text(to_chars("z0"));
		send_text(to_chars("AAB"));
		send_text(to_chars("Za9_"));

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 69 : 0;
			recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 6 : 0;
			n_sent = 0;
			while (n_sent < CHARS_PER_PHASE) begin
				make_text(t);
				send_text(t);
				n_sent += t.size();
			end
		end
		in_valid <= 1'b0;

		while (board.pending_decodes.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (board.n_fail == 0 && board.pending_decodes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (board.pending_decodes.size() != 0)
				$error("%0d expected results never arrived", board.pending_decodes.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
